### rtl/v3alu_pkg.sv
// types shared by the three-component fixed-point vector alu
// no dependencies
`timescale 1ns / 1ps

package v3alu_pkg;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_SCALE = 3'd2,
        KIND_DOT   = 3'd3,
        KIND_CROSS = 3'd4,
        KIND_MAG   = 3'd5,
        KIND_NORM  = 3'd6
    } t_kind;

    // item state carried along the pipeline
    typedef struct packed {
        t_kind           kind;
        logic [2:0][31:0] a;
        logic [2:0][31:0] r;
        logic            ov;
    } t_item;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // {overflow, value} after saturation to 32 bits
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] res;
        if (v > SAT_MAX) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < SAT_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

### rtl/vector3_fixed_point_alu_top.sv
// channel   | valid   | ready   | payload
// input     | i_valid | o_ready | i_kind, i_ax..i_bz, i_scale_factor
// output    | o_valid | i_ready | o_rx, o_ry, o_rz, o_overflow
//
// one item per cycle while the output is not stalled; every item passes the
// 32-step square root and the FRAC_BITS+1 step divider
// a stall on the output freezes the whole pipeline, nothing is lost or repeated
// synchronous active-low reset clears the valid bits only
// depends on v3alu_pkg
`timescale 1ns / 1ps

module vector3_fixed_point_alu_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_scale_factor,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic signed [31:0] o_rz,
    output logic               o_overflow
);
    import v3alu_pkg::*;

    localparam int SQ_STEPS = 32;
    localparam int QW       = FRAC_BITS + 1;
    localparam int DW       = FRAC_BITS + 34;
    localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

    logic en;

    // stage 1: multipliers and add/subtract
    logic signed [31:0] w_ma [6];
    logic signed [31:0] w_mb [6];
    logic signed [63:0] n_prod [6];
    logic signed [63:0] r_prod [6];
    logic [2:0][31:0]   w_b;
    t_item              n_it1, r_it1;
    logic               r_v1;

    // stage 2: product sums
    logic signed [65:0] n_sum [3];
    logic signed [65:0] r_sum [3];
    t_item              r_it2;
    logic               r_v2;

    // stage 3: rounding
    logic signed [65:0] w_rnd [3];
    t_item              n_it3, r_it3;
    logic [63:0]        r_sq;
    logic               r_v3;

    // square root
    logic [63:0]         n_sx [SQ_STEPS];
    logic [63:0]         n_sr [SQ_STEPS];
    logic [63:0]         r_sx [SQ_STEPS];
    logic [63:0]         r_sr [SQ_STEPS];
    t_item               r_sit [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_sv;

    // magnitude
    logic [32:0]   n_m, r_m;
    t_item         n_mit, r_mit;
    logic [DW-1:0] n_num [3];
    logic [DW-1:0] r_num [3];
    logic          r_mv;

    // divider
    logic [DW-1:0] n_drem [QW][3];
    logic [QW-1:0] n_dq   [QW][3];
    logic [DW-1:0] r_drem [QW][3];
    logic [QW-1:0] r_dq   [QW][3];
    logic [32:0]   r_dm   [QW];
    t_item         r_dit  [QW];
    logic [QW-1:0] r_dv;

    // output
    t_item n_out, r_out;
    logic  r_ov;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    assign w_b = {i_bz, i_by, i_bx};

    always_comb begin
        logic [32:0] s;
        logic signed [32:0] t;
        n_it1.kind = t_kind'(i_kind);
        n_it1.a    = {i_az, i_ay, i_ax};
        n_it1.r    = '0;
        n_it1.ov   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_ma[i]   = $signed(n_it1.a[i]);
            w_mb[i]   = $signed(n_it1.a[i]);
            w_ma[i+3] = '0;
            w_mb[i+3] = '0;
        end
        case (n_it1.kind)
            KIND_SCALE: begin
                for (int i = 0; i < 3; i++) w_mb[i] = i_scale_factor;
            end
            KIND_DOT: begin
                for (int i = 0; i < 3; i++) w_mb[i] = $signed(w_b[i]);
            end
            KIND_CROSS: begin
                w_ma[0] = i_ay; w_mb[0] = i_bz;
                w_ma[1] = i_az; w_mb[1] = i_bx;
                w_ma[2] = i_ax; w_mb[2] = i_by;
                w_ma[3] = i_az; w_mb[3] = i_by;
                w_ma[4] = i_ax; w_mb[4] = i_bz;
                w_ma[5] = i_ay; w_mb[5] = i_bx;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 6; i++) n_prod[i] = w_ma[i] * w_mb[i];
        if (n_it1.kind == KIND_ADD || n_it1.kind == KIND_SUB) begin
            for (int i = 0; i < 3; i++) begin
                if (n_it1.kind == KIND_SUB) begin
                    t = $signed({n_it1.a[i][31], n_it1.a[i]}) - $signed({w_b[i][31], w_b[i]});
                end else begin
                    t = $signed({n_it1.a[i][31], n_it1.a[i]}) + $signed({w_b[i][31], w_b[i]});
                end
                s = sat32({{33{t[32]}}, t});
                n_it1.r[i] = s[31:0];
                n_it1.ov   = n_it1.ov | s[32];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) n_sum[i] = '0;
        case (r_it1.kind)
            KIND_SCALE: begin
                for (int i = 0; i < 3; i++) n_sum[i] = {{2{r_prod[i][63]}}, r_prod[i]};
            end
            KIND_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_sum[i] = {{2{r_prod[i][63]}}, r_prod[i]}
                             - {{2{r_prod[i+3][63]}}, r_prod[i+3]};
                end
            end
            default: begin
                n_sum[0] = {{2{r_prod[0][63]}}, r_prod[0]} + {{2{r_prod[1][63]}}, r_prod[1]}
                         + {{2{r_prod[2][63]}}, r_prod[2]};
            end
        endcase
    end

    always_comb begin
        logic [32:0] s;
        n_it3 = r_it2;
        for (int i = 0; i < 3; i++) w_rnd[i] = (r_sum[i] + RND) >>> FRAC_BITS;
        case (r_it2.kind)
            KIND_SCALE, KIND_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    s = sat32(w_rnd[i]);
                    n_it3.r[i] = s[31:0];
                    n_it3.ov   = n_it3.ov | s[32];
                end
            end
            KIND_DOT: begin
                s = sat32(w_rnd[0]);
                n_it3.r[0] = s[31:0];
                n_it3.ov   = s[32];
            end
            default: begin
            end
        endcase
    end

    // one root bit per stage
    always_comb begin
        logic [63:0] x, r, t, b;
        for (int k = 0; k < SQ_STEPS; k++) begin
            b = 64'd1 << (2 * (SQ_STEPS - 1 - k));
            x = (k == 0) ? r_sq : r_sx[(k == 0) ? 0 : k - 1];
            r = (k == 0) ? 64'd0 : r_sr[(k == 0) ? 0 : k - 1];
            t = r + b;
            if (x >= t) begin
                n_sx[k] = x - t;
                n_sr[k] = (r >> 1) + b;
            end else begin
                n_sx[k] = x;
                n_sr[k] = r >> 1;
            end
        end
    end

    always_comb begin
        logic [31:0] mag;
        n_mit = r_sit[SQ_STEPS-1];
        n_m   = {1'b0, r_sr[SQ_STEPS-1][31:0]}
              + {32'd0, (r_sx[SQ_STEPS-1] > r_sr[SQ_STEPS-1])};
        if (n_mit.kind == KIND_MAG) begin
            if (n_m[32] || n_m[31]) begin
                n_mit.r[0] = 32'h7fff_ffff;
                n_mit.ov   = 1'b1;
            end else begin
                n_mit.r[0] = n_m[31:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            mag      = n_mit.a[i][31] ? (32'd0 - n_mit.a[i]) : n_mit.a[i];
            n_num[i] = (DW'(mag) << FRAC_BITS) + DW'(n_m >> 1);
        end
    end

    // one quotient bit per stage, three lanes
    always_comb begin
        logic [DW-1:0] rem, dsh;
        logic [QW-1:0] q;
        logic [32:0]   m;
        for (int j = 0; j < QW; j++) begin
            m   = (j == 0) ? r_m : r_dm[(j == 0) ? 0 : j - 1];
            dsh = DW'(m) << (QW - 1 - j);
            for (int i = 0; i < 3; i++) begin
                rem = (j == 0) ? r_num[i] : r_drem[(j == 0) ? 0 : j - 1][i];
                q   = (j == 0) ? '0 : r_dq[(j == 0) ? 0 : j - 1][i];
                if (rem >= dsh) begin
                    n_drem[j][i] = rem - dsh;
                    n_dq[j][i]   = {q[QW-2:0], 1'b1};
                end else begin
                    n_drem[j][i] = rem;
                    n_dq[j][i]   = {q[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        n_out = r_dit[QW-1];
        if (n_out.kind == KIND_NORM && r_dm[QW-1] != '0) begin
            for (int i = 0; i < 3; i++) begin
                if (n_out.a[i][31]) begin
                    n_out.r[i] = 32'd0 - 32'(r_dq[QW-1][i]);
                end else begin
                    n_out.r[i] = 32'(r_dq[QW-1][i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_sv <= '0;
            r_mv <= 1'b0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_sv <= {r_sv[SQ_STEPS-2:0], r_v3};
            r_mv <= r_sv[SQ_STEPS-1];
            r_dv <= {r_dv[QW-2:0], r_mv};
            r_ov <= r_dv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it1 <= n_it1;
            for (int i = 0; i < 6; i++) r_prod[i] <= n_prod[i];
            r_it2 <= r_it1;
            for (int i = 0; i < 3; i++) r_sum[i] <= n_sum[i];
            r_it3 <= n_it3;
            r_sq  <= r_sum[0][63:0];
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sx[k] <= n_sx[k];
                r_sr[k] <= n_sr[k];
            end
            r_sit[0] <= r_it3;
            for (int k = 1; k < SQ_STEPS; k++) r_sit[k] <= r_sit[k-1];
            r_mit <= n_mit;
            r_m   <= n_m;
            for (int i = 0; i < 3; i++) r_num[i] <= n_num[i];
            r_dit[0] <= r_mit;
            r_dm[0]  <= r_m;
            for (int j = 1; j < QW; j++) begin
                r_dit[j] <= r_dit[j-1];
                r_dm[j]  <= r_dm[j-1];
            end
            for (int j = 0; j < QW; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[j][i] <= n_drem[j][i];
                    r_dq[j][i]   <= n_dq[j][i];
                end
            end
            r_out <= n_out;
        end
    end

    assign o_valid    = r_ov;
    assign o_rx       = $signed(r_out.r[0]);
    assign o_ry       = $signed(r_out.r[1]);
    assign o_rz       = $signed(r_out.r[2]);
    assign o_overflow = r_out.ov;

endmodule
